>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

`endif

>>> rtl/core/ssd_pkg.sv
package ssd_pkg;

  localparam int BUF_DEPTH      = 8;
  localparam int ADDR_W         = 3;
  localparam int SEG_W          = 8;
  localparam int DIGITS_DEFAULT = 8;

  localparam logic [SEG_W-1:0] BLANK        = 8'hFF;
  localparam logic [SEG_W-1:0] UNKNOWN_CHAR = 8'hF7;

  localparam logic [2:0] MODE_TICK      = 3'd0;
  localparam logic [2:0] MODE_RAW       = 3'd1;
  localparam logic [2:0] MODE_READ      = 3'd2;
  localparam logic [2:0] MODE_CHAR      = 3'd3;
  localparam logic [2:0] MODE_NUMBER    = 3'd4;
  localparam logic [2:0] MODE_CLR_RANGE = 3'd5;
  localparam logic [2:0] MODE_CLR_ALL   = 3'd6;

  // Segment pattern of one decimal digit, active low.
  function automatic logic [SEG_W-1:0] digit_code(input logic [3:0] d);
    logic [SEG_W-1:0] p;
    case (d)
      4'd0:    p = 8'hC0;
      4'd1:    p = 8'hF9;
      4'd2:    p = 8'hA4;
      4'd3:    p = 8'hB0;
      4'd4:    p = 8'h99;
      4'd5:    p = 8'h92;
      4'd6:    p = 8'h82;
      4'd7:    p = 8'hF8;
      4'd8:    p = 8'h80;
      4'd9:    p = 8'h90;
      default: p = BLANK;
    endcase
    return p;
  endfunction

  // Segment pattern of an ASCII character; lower case is folded to upper case.
  function automatic logic [SEG_W-1:0] char_pattern(input logic [7:0] c);
    logic [7:0]       up;
    logic [SEG_W-1:0] p;
    up = c;
    if (c inside {[8'h61:8'h7A]}) begin
      up = c - 8'h20;
    end
    if (c inside {[8'h30:8'h39]}) begin
      p = digit_code(4'(c - 8'h30));
    end else begin
      case (up)
        8'h41:   p = 8'h88;  // A
        8'h53:   p = 8'h12;  // S
        8'h48:   p = 8'h89;  // H
        8'h4C:   p = 8'hC7;  // L
        8'h4E:   p = 8'hC8;  // N
        8'h45:   p = 8'h86;  // E
        8'h52:   p = 8'hAF;  // R
        8'h55:   p = 8'hC1;  // U
        8'h50:   p = 8'h8C;  // P
        8'h4F:   p = 8'hA3;  // O
        8'h2D:   p = 8'hBF;  // minus
        8'h20:   p = 8'hFF;  // space
        8'h3E:   p = 8'hFE;  // greater-than
        8'h46:   p = 8'h8E;  // F
        default: p = UNKNOWN_CHAR;
      endcase
    end
    return p;
  endfunction

endpackage

>>> rtl/core/ssd_ram.sv
module ssd_ram #(
  parameter int WIDTH = ssd_pkg::SEG_W,
  parameter int DEPTH = ssd_pkg::BUF_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/seven_segment_scan_display.sv
// Multiplexed seven-segment display controller with active-low segments and
// active-low digit selects. A request item is taken at a rising edge where
// start is high and busy is low; the fields in_mode, in_position,
// in_digit_count, in_segment_byte, in_char_code and in_number describe it.
// Every item produces exactly one result: out_valid is high for one cycle
// with the held pins on out_com_lines and out_seg_lines and, for a read, the
// buffer byte on out_read_data (255 for every other request). The receiver
// cannot hold results off, and none is needed since one item runs at a time.
// Write raw, put char, both clears and the unused mode finish at once: the
// strobe is high in the cycle after acceptance and busy never rises, so such
// items may follow each other on every edge.
// Scan tick and read hold busy in the read state while the buffer RAM
// delivers its registered data; the strobe is registered from that state.
// Show number with digits to write holds busy through binary-to-decimal
// conversion in the BCD state, four bits a cycle, and then through the
// write state, one digit per cycle through the single RAM write port; its
// strobe is registered from the last digit written.
// Synchronous reset blanks the buffer through eight valid flags, parks the
// scan on digit zero and turns all pins off (0xFF); no clearing pass runs.
// The pins only change on a scan tick and hold their value in between.

`include "assert_macros.svh"

module seven_segment_scan_display #(
  parameter int DIGITS = ssd_pkg::DIGITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_mode,
  input  logic [3:0]  in_position,
  input  logic [3:0]  in_digit_count,
  input  logic [7:0]  in_segment_byte,
  input  logic [7:0]  in_char_code,
  input  logic [31:0] in_number,
  output logic        out_valid,
  output logic [7:0]  out_com_lines,
  output logic [7:0]  out_seg_lines,
  output logic [7:0]  out_read_data
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_BCD   = 2'd2;
  localparam logic [1:0] ST_WRITE = 2'd3;

  localparam int         DEPTH     = ssd_pkg::BUF_DEPTH;
  localparam int         AW        = ssd_pkg::ADDR_W;
  localparam logic [4:0] DIG5      = 5'(DIGITS);
  localparam logic [3:0] DIG_LAST  = 4'(DIGITS - 1);
  localparam logic [2:0] SCAN_LAST = 3'(DIGITS - 1);

  // Four double-dabble steps on eight BCD digits. The carry out of the top
  // digit is dropped, so the BCD word holds the value modulo 10^8, which is
  // all the display can show.
  function automatic logic [63:0] dabble4(input logic [31:0] bcd_in,
                                          input logic [31:0] bin_in);
    logic [31:0] bcd;
    logic [31:0] bin;
    bcd = bcd_in;
    bin = bin_in;
    for (int j = 0; j < 4; j++) begin
      for (int d = 0; d < 8; d++) begin
        if (bcd[4*d +: 4] >= 4'd5) begin
          bcd[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
        end
      end
      bcd = {bcd[30:0], bin[31]};
      bin = {bin[30:0], 1'b0};
    end
    return {bcd, bin};
  endfunction

  logic [1:0]       state_r, state_nxt;
  logic [2:0]       scan_r, scan_nxt;
  logic [7:0]       com_r, com_nxt;
  logic [7:0]       seg_r, seg_nxt;
  logic [7:0]       read_r, read_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [2:0]       op_r, op_nxt;
  logic [3:0]       pos_r, pos_nxt;
  logic [3:0]       k_r, k_nxt;
  logic [3:0]       end_r, end_nxt;
  logic [2:0]       step_r, step_nxt;
  logic [31:0]      bcd_r, bcd_nxt;
  logic [31:0]      bin_r, bin_nxt;
  logic [DEPTH-1:0] valid_r, valid_nxt;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [7:0]       ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [7:0]       ram_rdata;

  logic [DEPTH-1:0] clr_mask;
  logic [4:0]       num_sum;
  logic [4:0]       num_end;
  logic [3:0]       char_idx;
  logic [63:0]      dab;

  logic             quick_acc;
  logic             blank_res;

  ssd_ram #(
    .WIDTH (ssd_pkg::SEG_W),
    .DEPTH (DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Clear range: the start is counted from the right and clamped to the last
  // digit, and the count is cut so that the range stops at the left end.
  always_comb begin
    logic [3:0] p;
    logic [3:0] c;
    logic [4:0] hi;
    logic [3:0] kk;
    p = (in_position > DIG_LAST) ? DIG_LAST : in_position;
    c = in_digit_count;
    if (({1'b0, c} + {1'b0, p}) > DIG5) begin
      c = 4'(DIG5 - {1'b0, p});
    end
    hi = {1'b0, p} + {1'b0, c};
    clr_mask = '0;
    for (int e = 0; e < DEPTH; e++) begin
      kk = 4'(DIGITS - 1 - e);
      if (e < DIGITS) begin
        clr_mask[e] = (kk >= p) && ({1'b0, kk} < hi);
      end
    end
  end

  assign num_sum  = {1'b0, in_position} + {1'b0, in_digit_count};
  assign num_end  = (num_sum > DIG5) ? DIG5 : num_sum;
  assign char_idx = DIG_LAST - in_position;
  assign dab      = dabble4(bcd_r, bin_r);

  always_comb begin
    state_nxt     = state_r;
    scan_nxt      = scan_r;
    com_nxt       = com_r;
    seg_nxt       = seg_r;
    read_nxt      = read_r;
    out_valid_nxt = 1'b0;
    op_nxt        = op_r;
    pos_nxt       = pos_r;
    k_nxt         = k_r;
    end_nxt       = end_r;
    step_nxt      = step_r;
    bcd_nxt       = bcd_r;
    bin_nxt       = bin_r;
    valid_nxt     = valid_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_raddr     = scan_r;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt   = in_mode;
          pos_nxt  = in_position;
          read_nxt = ssd_pkg::BLANK;
          case (in_mode)
            ssd_pkg::MODE_TICK: begin
              ram_raddr = scan_r;
              state_nxt = ST_READ;
            end
            ssd_pkg::MODE_READ: begin
              ram_raddr = in_position[AW-1:0];
              state_nxt = ST_READ;
            end
            ssd_pkg::MODE_RAW: begin
              if ({1'b0, in_position} < DIG5) begin
                ram_we               = 1'b1;
                ram_waddr            = in_position[AW-1:0];
                ram_wdata            = in_segment_byte;
                valid_nxt[ram_waddr] = 1'b1;
              end
              out_valid_nxt = 1'b1;
            end
            ssd_pkg::MODE_CHAR: begin
              if (({1'b0, in_position} < DIG5) && (in_char_code != 8'd0)) begin
                ram_we               = 1'b1;
                ram_waddr            = char_idx[AW-1:0];
                ram_wdata            = ssd_pkg::char_pattern(in_char_code);
                valid_nxt[ram_waddr] = 1'b1;
              end
              out_valid_nxt = 1'b1;
            end
            ssd_pkg::MODE_NUMBER: begin
              if ({1'b0, in_position} < num_end) begin
                bin_nxt   = in_number;
                bcd_nxt   = '0;
                step_nxt  = '0;
                k_nxt     = in_position;
                end_nxt   = num_end[3:0];
                state_nxt = ST_BCD;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            ssd_pkg::MODE_CLR_RANGE: begin
              valid_nxt     = valid_r & ~clr_mask;
              out_valid_nxt = 1'b1;
            end
            ssd_pkg::MODE_CLR_ALL: begin
              valid_nxt     = '0;
              out_valid_nxt = 1'b1;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        if (op_r == ssd_pkg::MODE_TICK) begin
          seg_nxt  = valid_r[scan_r] ? ram_rdata : ssd_pkg::BLANK;
          com_nxt  = ~(8'h80 >> scan_r);
          scan_nxt = (scan_r >= SCAN_LAST) ? 3'd0 : scan_r + 3'd1;
        end else if (({1'b0, pos_r} < DIG5) && valid_r[pos_r[AW-1:0]]) begin
          read_nxt = ram_rdata;
        end
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_BCD: begin
        bcd_nxt  = dab[63:32];
        bin_nxt  = dab[31:0];
        step_nxt = step_r + 3'd1;
        if (step_r == 3'd7) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        ram_we               = 1'b1;
        ram_waddr            = k_r[AW-1:0];
        ram_wdata            = ssd_pkg::digit_code(bcd_r[3:0]);
        valid_nxt[ram_waddr] = 1'b1;
        bcd_nxt              = {4'd0, bcd_r[31:4]};
        k_nxt                = k_r + 4'd1;
        if ((k_r + 4'd1) == end_r) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scan_r      <= '0;
      com_r       <= ssd_pkg::BLANK;
      seg_r       <= ssd_pkg::BLANK;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      scan_r      <= scan_nxt;
      com_r       <= com_nxt;
      seg_r       <= seg_nxt;
      out_valid_r <= out_valid_nxt;
      valid_r     <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    read_r <= read_nxt;
    op_r   <= op_nxt;
    pos_r  <= pos_nxt;
    k_r    <= k_nxt;
    end_r  <= end_nxt;
    step_r <= step_nxt;
    bcd_r  <= bcd_nxt;
    bin_r  <= bin_nxt;
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_com_lines = com_r;
  assign out_seg_lines = seg_r;
  assign out_read_data = read_r;

  // Items that need no RAM read and no conversion, and results of anything
  // but a read.
  assign quick_acc = start && !busy &&
                     !(in_mode inside {ssd_pkg::MODE_TICK, ssd_pkg::MODE_READ,
                                       ssd_pkg::MODE_NUMBER});
  assign blank_res = out_valid && (op_r != ssd_pkg::MODE_READ);

  // Requests that need no RAM read and no conversion finish at once.
  `SSD_ASSERT_NEXT(a_quick_done, clk, rst_n, quick_acc, out_valid && !busy)
  // The read state always returns to idle with a result in the cycle after it.
  `SSD_ASSERT_NEXT(a_read_done, clk, rst_n, state_r == ST_READ, out_valid && (state_r == ST_IDLE))
  // Only a read may return anything but the blank byte.
  `SSD_ASSERT_IMP(a_read_blank, clk, rst_n, blank_res, out_read_data == ssd_pkg::BLANK)
  // At most one digit select is driven at any time.
  `SSD_ASSERT_IMP(a_one_com, clk, rst_n, 1'b1, $countones(~out_com_lines) <= 1)

endmodule

>>> verif/tb_top.sv
module tb_top;

  // Mode value seven is left unused by the block; it must change nothing.
  localparam logic [2:0] MODE_UNUSED = 3'd7;
  localparam int NUM_DIGITS = ssd_pkg::DIGITS_DEFAULT;
  localparam int RANDOM_ITEMS = 1100;
  // The longest request is a number written over eight digits.
  localparam int SETTLE_CYCLES = 24;

  // Characters that have a pattern of their own, in upper case.
  localparam logic [7:0] GLYPH_CHARS [14] = '{
    8'h41, 8'h53, 8'h48, 8'h4C, 8'h4E, 8'h45, 8'h52,  // A S H L N E R
    8'h55, 8'h50, 8'h4F, 8'h2D, 8'h20, 8'h3E, 8'h46   // U P O - space > F
  };

  // Pins and read byte that one request is expected to leave behind.
  typedef struct packed {
    logic [7:0] com;
    logic [7:0] seg;
    logic [7:0] rd;
  } pin_snapshot_t;

  // Shadow copy of the display controller. It applies every accepted request
  // to its own buffer, scan position and pins, queues the pins and read byte
  // that the request should produce, and compares them with what comes out.
  class segment_display_tracker;
    logic [7:0]    digit_buf [8];
    logic [2:0]    scan;
    logic [7:0]    com_pins;
    logic [7:0]    seg_pins;
    pin_snapshot_t pending_pins [$];
    int unsigned   errors;

    function new();
      foreach (digit_buf[i]) digit_buf[i] = ssd_pkg::BLANK;
      scan = 3'd0;
      com_pins = ssd_pkg::BLANK;
      seg_pins = ssd_pkg::BLANK;
      errors = 0;
    endfunction

    function logic [7:0] decimal_glyph(input int unsigned d);
      case (d)
        0:       return 8'hC0;
        1:       return 8'hF9;
        2:       return 8'hA4;
        3:       return 8'hB0;
        4:       return 8'h99;
        5:       return 8'h92;
        6:       return 8'h82;
        7:       return 8'hF8;
        8:       return 8'h80;
        default: return 8'h90;
      endcase
    endfunction

    // Digits use the decimal table; letters are folded to upper case first.
    function logic [7:0] glyph_for(input logic [7:0] c);
      logic [7:0] up;
      if (c >= 8'h30 && c <= 8'h39) return decimal_glyph(c - 8'h30);
      up = (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
      case (up)
        8'h41:   return 8'h88;
        8'h53:   return 8'h12;
        8'h48:   return 8'h89;
        8'h4C:   return 8'hC7;
        8'h4E:   return 8'hC8;
        8'h45:   return 8'h86;
        8'h52:   return 8'hAF;
        8'h55:   return 8'hC1;
        8'h50:   return 8'h8C;
        8'h4F:   return 8'hA3;
        8'h2D:   return 8'hBF;
        8'h20:   return 8'hFF;
        8'h3E:   return 8'hFE;
        8'h46:   return 8'h8E;
        default: return ssd_pkg::UNKNOWN_CHAR;
      endcase
    endfunction

    function void note_request(input logic [2:0] mode, input logic [3:0] pos,
                               input logic [3:0] cnt, input logic [7:0] raw,
                               input logic [7:0] ch, input logic [31:0] num);
      logic [7:0]  rd;
      logic [31:0] rest;
      int unsigned k;
      int unsigned last;
      int unsigned first;
      int unsigned span;
      rd = ssd_pkg::BLANK;
      case (mode)
        ssd_pkg::MODE_TICK: begin
          seg_pins = digit_buf[scan];
          com_pins = ~(8'h80 >> scan);
          if (int'(scan) + 1 >= NUM_DIGITS) scan = 3'd0;
          else scan = scan + 3'd1;
        end
        ssd_pkg::MODE_RAW: begin
          if (pos < NUM_DIGITS) digit_buf[pos[2:0]] = raw;
        end
        ssd_pkg::MODE_READ: begin
          if (pos < NUM_DIGITS) rd = digit_buf[pos[2:0]];
        end
        ssd_pkg::MODE_CHAR: begin
          // A zero code marks the end of a text and writes nothing.
          if (pos < NUM_DIGITS && ch != 8'h00) begin
            digit_buf[NUM_DIGITS - 1 - pos] = glyph_for(ch);
          end
        end
        ssd_pkg::MODE_NUMBER: begin
          last = pos + cnt;
          if (last > NUM_DIGITS) last = NUM_DIGITS;
          rest = num;
          for (k = pos; k < last; k++) begin
            digit_buf[k] = decimal_glyph(rest % 10);
            rest = rest / 10;
          end
        end
        ssd_pkg::MODE_CLR_RANGE: begin
          // Counted from the right; start and length are both clamped.
          first = pos;
          if (first > NUM_DIGITS - 1) first = NUM_DIGITS - 1;
          span = cnt;
          if (span + first > NUM_DIGITS) span = NUM_DIGITS - first;
          for (k = first; k < first + span; k++) begin
            digit_buf[NUM_DIGITS - 1 - k] = ssd_pkg::BLANK;
          end
        end
        ssd_pkg::MODE_CLR_ALL: begin
          foreach (digit_buf[i]) digit_buf[i] = ssd_pkg::BLANK;
        end
        default: begin
        end
      endcase
      pending_pins.push_back('{com: com_pins, seg: seg_pins, rd: rd});
    endfunction

    function void check_result(input logic [7:0] com, input logic [7:0] seg,
                               input logic [7:0] rd);
      pin_snapshot_t want;
      if (pending_pins.size() == 0) begin
        $error("result without an outstanding request: %s %h %h %h",
               "com_lines seg_lines read_data", com, seg, rd);
        errors++;
        return;
      end
      want = pending_pins.pop_front();
      if (com !== want.com) begin
        $error("com_lines: expected %h, got %h", want.com, com);
        errors++;
      end
      if (seg !== want.seg) begin
        $error("seg_lines: expected %h, got %h", want.seg, seg);
        errors++;
      end
      if (rd !== want.rd) begin
        $error("read_data: expected %h, got %h", want.rd, rd);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [2:0]  in_mode = 3'd0;
  logic [3:0]  in_position = 4'd0;
  logic [3:0]  in_digit_count = 4'd0;
  logic [7:0]  in_segment_byte = 8'd0;
  logic [7:0]  in_char_code = 8'd0;
  logic [31:0] in_number = 32'd0;
  wire         busy;
  wire         out_valid;
  wire  [7:0]  out_com_lines;
  wire  [7:0]  out_seg_lines;
  wire  [7:0]  out_read_data;

  segment_display_tracker tracker = new();

  seven_segment_scan_display uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_position    (in_position),
    .in_digit_count (in_digit_count),
    .in_segment_byte(in_segment_byte),
    .in_char_code   (in_char_code),
    .in_number      (in_number),
    .out_valid      (out_valid),
    .out_com_lines  (out_com_lines),
    .out_seg_lines  (out_seg_lines),
    .out_read_data  (out_read_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 0;
  end

  // Both sides are observed at the rising edge. A result is checked before a
  // request taken at the same edge is noted, although a result can never
  // belong to a request accepted at that very edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) tracker.check_result(out_com_lines, out_seg_lines, out_read_data);
      if (start && !busy) begin
        tracker.note_request(in_mode, in_position, in_digit_count, in_segment_byte,
                             in_char_code, in_number);
      end
    end
  end

  // Presents one request and holds it until the block takes it. Returns at the
  // edge of acceptance, so a following call keeps start high without a dip.
  task automatic issue(input logic [2:0] mode, input logic [3:0] pos,
                       input logic [3:0] cnt, input logic [7:0] raw,
                       input logic [7:0] ch, input logic [31:0] num);
    start           <= 1'b1;
    in_mode         <= mode;
    in_position     <= pos;
    in_digit_count  <= cnt;
    in_segment_byte <= raw;
    in_char_code    <= ch;
    in_number       <= num;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Sender gap; the fields carry rubbish meanwhile, which must be ignored.
  task automatic pause(input int unsigned cycles);
    if (cycles != 0) begin
      start           <= 1'b0;
      in_mode         <= 3'($urandom);
      in_position     <= 4'($urandom);
      in_digit_count  <= 4'($urandom);
      in_segment_byte <= 8'($urandom);
      in_char_code    <= 8'($urandom);
      in_number       <= $urandom;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Holds off until every outstanding result has come back, then lets the
  // block settle for a little longer than its slowest request.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (tracker.pending_pins.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One random request. Reads and ticks are common so that the buffer and
  // the pins are looked at often; positions lean towards the digits in use.
  task automatic issue_random();
    int unsigned roll;
    logic [2:0]  mode;
    logic [3:0]  pos;
    logic [7:0]  ch;
    logic [31:0] num;
    roll = $urandom_range(99);
    if (roll < 20) mode = ssd_pkg::MODE_TICK;
    else if (roll < 32) mode = ssd_pkg::MODE_RAW;
    else if (roll < 50) mode = ssd_pkg::MODE_READ;
    else if (roll < 64) mode = ssd_pkg::MODE_CHAR;
    else if (roll < 78) mode = ssd_pkg::MODE_NUMBER;
    else if (roll < 88) mode = ssd_pkg::MODE_CLR_RANGE;
    else if (roll < 92) mode = ssd_pkg::MODE_CLR_ALL;
    else if (roll < 95) mode = MODE_UNUSED;
    else mode = ssd_pkg::MODE_TICK;
    pos = ($urandom_range(4) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(7));
    case ($urandom_range(3))
      0: ch = 8'($urandom);
      1: ch = 8'h30 + 8'($urandom_range(9));
      2: begin
        ch = GLYPH_CHARS[$urandom_range(13)];
        if (ch >= 8'h41 && ch <= 8'h5A && $urandom_range(1) == 1) ch = ch | 8'h20;
      end
      default: ch = 8'h61 + 8'($urandom_range(25));
    endcase
    case ($urandom_range(3))
      0: num = $urandom_range(999);
      1: num = 32'hFFFF_FFFF - $urandom_range(1000);
      default: num = $urandom;
    endcase
    issue(mode, pos, 4'($urandom_range(15)), 8'($urandom), ch, num);
  endtask

  initial begin
    int unsigned sent;
    int unsigned burst;
    bit          drained_midway;
    sent = 0;
    drained_midway = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests: the blank buffer after reset, the extremes of every
    // field, positions past the last digit, the zero character, unknown and
    // lower-case characters, counts of zero and clamped ranges, the unused
    // mode, and a full turn of the scan.
    issue(ssd_pkg::MODE_TICK, 4'd0, 4'd0, 8'h00, 8'h00, 32'd0);
    issue(ssd_pkg::MODE_READ, 4'd8, 4'd0, 8'h00, 8'h00, 32'd0);
    issue(ssd_pkg::MODE_RAW, 4'd0, 4'd0, 8'h00, 8'h00, 32'd0);
    issue(ssd_pkg::MODE_RAW, 4'd7, 4'd0, 8'h5A, 8'h00, 32'd0);
    issue(ssd_pkg::MODE_RAW, 4'd15, 4'd15, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    issue(ssd_pkg::MODE_READ, 4'd0, 4'd0, 8'h00, 8'h00, 32'd0);
    issue(ssd_pkg::MODE_READ, 4'd15, 4'd0, 8'h00, 8'h00, 32'd0);
    issue(ssd_pkg::MODE_CHAR, 4'd0, 4'd0, 8'h00, 8'h00, 32'd0);
    issue(ssd_pkg::MODE_CHAR, 4'd9, 4'd0, 8'h00, 8'h45, 32'd0);
    issue(ssd_pkg::MODE_CHAR, 4'd1, 4'd0, 8'h00, 8'h61, 32'd0);
    issue(ssd_pkg::MODE_CHAR, 4'd2, 4'd0, 8'h00, 8'h39, 32'd0);
    issue(ssd_pkg::MODE_CHAR, 4'd3, 4'd0, 8'h00, 8'hFF, 32'd0);
    issue(ssd_pkg::MODE_CHAR, 4'd4, 4'd0, 8'h00, 8'h3E, 32'd0);
    issue(ssd_pkg::MODE_NUMBER, 4'd0, 4'd15, 8'h00, 8'h00, 32'hFFFF_FFFF);
    issue(ssd_pkg::MODE_NUMBER, 4'd8, 4'd15, 8'h00, 8'h00, 32'd12345);
    issue(ssd_pkg::MODE_NUMBER, 4'd3, 4'd0, 8'h00, 8'h00, 32'd777);
    issue(ssd_pkg::MODE_CLR_RANGE, 4'd15, 4'd15, 8'h00, 8'h00, 32'd0);
    issue(ssd_pkg::MODE_CLR_RANGE, 4'd2, 4'd0, 8'h00, 8'h00, 32'd0);
    issue(ssd_pkg::MODE_NUMBER, 4'd0, 4'd8, 8'h00, 8'h00, 32'd0);
    issue(MODE_UNUSED, 4'd0, 4'd0, 8'h00, 8'h00, 32'd0);
    repeat (8) issue(ssd_pkg::MODE_TICK, 4'd0, 4'd0, 8'h00, 8'h00, 32'd0);
    issue(ssd_pkg::MODE_CLR_ALL, 4'd0, 4'd0, 8'h00, 8'h00, 32'd0);
    issue(ssd_pkg::MODE_TICK, 4'd0, 4'd0, 8'h00, 8'h00, 32'd0);
    pause(3);

    // Random bursts with random gaps, now and then a long unbroken run, and
    // occasionally a full stop until the block has caught up.
    while (sent < RANDOM_ITEMS) begin
      burst = ($urandom_range(5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      repeat (burst) begin
        issue_random();
        sent++;
      end
      if ((!drained_midway && sent >= RANDOM_ITEMS / 2) || $urandom_range(39) == 0) begin
        drained_midway = 1'b1;
        drain();
      end else if ($urandom_range(9) == 0) begin
        pause($urandom_range(10, 20));
      end else begin
        pause($urandom_range(0, 6));
      end
    end

    drain();
    if (tracker.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake or a result that never arrives.
  initial begin
    #3000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/ssd_pkg.sv
rtl/core/ssd_ram.sv
rtl/core/seven_segment_scan_display.sv
verif/tb_top.sv
